// File: src/mavf_pkg.sv
// Shared types and constants for the moving average filter.
package mavf_pkg;

  localparam int SAMPLE_W = 32;
  localparam int CFG_W    = 7;
  localparam logic [CFG_W-1:0] WINDOW_RESET = 7'd8;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ADD,
    ST_DIV_LOAD,
    ST_DIV,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic clear;
    logic load;
    logic shift;
  } acc_ctrl_t;

  typedef struct packed {
    logic load;
    logic shift;
  } div_ctrl_t;

endpackage

// File: src/moving_average_filter_top.sv
// Moving average filter top level: control sequencer, window state and output register.
//
//   channel | signals                          | moves
//   --------+----------------------------------+-------------------------------
//   cfg     | cfg_write_en, cfg_write_data     | window_length, empties store
//   in      | in_valid, in_ready, sample       | one Q16.16 sample word
//   out     | out_valid, out_ready, filtered,  | pass-through or mean word
//           | averaged                         |
//
// A word passes through the bit-serial sum update while the window fills, and through the
// divider as well once it is full; SUM_W = 32 + clog2(MAX_WINDOW). The bit-serial
// sum update and the bit-serial divider each take one bit a cycle.
// rst is synchronous; it empties the store and sets window_length to 8.
// in_ready is high in idle only; a finished word waits in the output register while the
// next word is taken, and the sequencer holds at the end until that register is free.
module moving_average_filter_top #(
  parameter int MAX_WINDOW = 64
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write_en,
  input  logic [mavf_pkg::CFG_W-1:0]           cfg_write_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [mavf_pkg::SAMPLE_W-1:0] sample,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [mavf_pkg::SAMPLE_W-1:0] filtered,
  output logic                                 averaged
);

  localparam int PTR_W = $clog2(MAX_WINDOW);
  localparam int LEN_W = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W = mavf_pkg::SAMPLE_W + PTR_W;
  localparam int CNT_W = $clog2(SUM_W);
  localparam int CMP_W = (LEN_W > mavf_pkg::CFG_W) ? LEN_W : mavf_pkg::CFG_W;

  mavf_pkg::state_t state;
  mavf_pkg::state_t state_next;

  logic [mavf_pkg::CFG_W-1:0]           window_length;
  logic [LEN_W-1:0]                     fill_count;
  logic [PTR_W-1:0]                     oldest_pos;
  logic                                 fill_mode;
  logic signed [mavf_pkg::SAMPLE_W-1:0] sample_hold;
  logic [CNT_W-1:0]                     bit_cnt;

  logic [CMP_W-1:0]                     wl_ext;
  logic [LEN_W-1:0]                     len_eff;
  logic [PTR_W-1:0]                     pos_eff;
  logic [LEN_W-1:0]                     pos_inc;
  logic [PTR_W-1:0]                     ring_addr;
  logic                                 fill_now;
  logic                                 accept;
  logic                                 out_load;
  logic [mavf_pkg::SAMPLE_W-1:0]        ring_rdata;
  logic signed [mavf_pkg::SAMPLE_W-1:0] old_word;
  logic                                 sum_negative;
  logic [SUM_W-1:0]                     sum_magnitude;
  logic signed [mavf_pkg::SAMPLE_W-1:0] mean;
  mavf_pkg::acc_ctrl_t                  acc_ctrl;
  mavf_pkg::div_ctrl_t                  div_ctrl;

  // window length clamped to 1..MAX_WINDOW
  always_comb begin
    wl_ext = CMP_W'(window_length);
    if (window_length == '0) begin
      len_eff = LEN_W'(1);
    end else if (wl_ext > CMP_W'(MAX_WINDOW)) begin
      len_eff = LEN_W'(MAX_WINDOW);
    end else begin
      len_eff = LEN_W'(wl_ext);
    end
    pos_eff   = (LEN_W'(oldest_pos) >= len_eff) ? '0 : oldest_pos;
    pos_inc   = LEN_W'(pos_eff) + 1'b1;
    fill_now  = fill_count < len_eff;
    ring_addr = fill_now ? fill_count[PTR_W-1:0] : pos_eff;
  end

  assign accept   = in_valid && in_ready;
  assign old_word = fill_mode ? '0 : ring_rdata;

  always_comb begin
    state_next     = state;
    in_ready       = 1'b0;
    out_load       = 1'b0;
    acc_ctrl       = '0;
    acc_ctrl.clear = cfg_write_en;
    div_ctrl       = '0;
    unique case (state)
      mavf_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = mavf_pkg::ST_LOAD;
        end
      end
      mavf_pkg::ST_LOAD: begin
        acc_ctrl.load = 1'b1;
        state_next    = mavf_pkg::ST_ADD;
      end
      mavf_pkg::ST_ADD: begin
        acc_ctrl.shift = 1'b1;
        if (bit_cnt == '0) begin
          state_next = fill_mode ? mavf_pkg::ST_DONE : mavf_pkg::ST_DIV_LOAD;
        end
      end
      mavf_pkg::ST_DIV_LOAD: begin
        div_ctrl.load = 1'b1;
        state_next    = mavf_pkg::ST_DIV;
      end
      mavf_pkg::ST_DIV: begin
        div_ctrl.shift = 1'b1;
        if (bit_cnt == '0) begin
          state_next = mavf_pkg::ST_DONE;
        end
      end
      mavf_pkg::ST_DONE: begin
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = mavf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = mavf_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mavf_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= mavf_pkg::WINDOW_RESET;
      fill_count    <= '0;
      oldest_pos    <= '0;
    end else if (cfg_write_en) begin
      window_length <= cfg_write_data;
      fill_count    <= '0;
      oldest_pos    <= '0;
    end else if (accept) begin
      if (fill_now) begin
        fill_count <= fill_count + 1'b1;
      end else begin
        oldest_pos <= (pos_inc >= len_eff) ? '0 : pos_inc[PTR_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fill_mode   <= fill_now;
      sample_hold <= sample;
    end
    if (state == mavf_pkg::ST_LOAD || state == mavf_pkg::ST_DIV_LOAD) begin
      bit_cnt <= CNT_W'(SUM_W - 1);
    end else if (state == mavf_pkg::ST_ADD || state == mavf_pkg::ST_DIV) begin
      bit_cnt <= bit_cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      filtered <= fill_mode ? sample_hold : mean;
      averaged <= ~fill_mode;
    end
  end

  mavf_ring #(
    .DEPTH  (MAX_WINDOW),
    .ADDR_W (PTR_W)
  ) u_ring (
    .clk    (clk),
    .access (accept),
    .addr   (ring_addr),
    .wdata  (sample),
    .rdata  (ring_rdata)
  );

  mavf_acc #(
    .SUM_W (SUM_W)
  ) u_acc (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (acc_ctrl),
    .new_word  (sample_hold),
    .old_word  (old_word),
    .negative  (sum_negative),
    .magnitude (sum_magnitude)
  );

  mavf_div #(
    .SUM_W (SUM_W),
    .LEN_W (LEN_W)
  ) u_div (
    .clk      (clk),
    .ctrl     (div_ctrl),
    .dividend (sum_magnitude),
    .negative (sum_negative),
    .divisor  (len_eff),
    .quotient (mean)
  );

endmodule

// File: src/mavf_ring.sv
// Sample ring store: a single address port that writes and gives a registered read.
module mavf_ring #(
  parameter int DEPTH  = 64,
  parameter int ADDR_W = 6
) (
  input  logic                              clk,
  input  logic                              access,
  input  logic [ADDR_W-1:0]                 addr,
  input  logic [mavf_pkg::SAMPLE_W-1:0]     wdata,
  output logic [mavf_pkg::SAMPLE_W-1:0]     rdata
);

  logic [mavf_pkg::SAMPLE_W-1:0] mem [DEPTH];

  // read-first: the old word comes out while the new one goes in
  always_ff @(posedge clk) begin
    if (access) begin
      rdata     <= mem[addr];
      mem[addr] <= wdata;
    end
  end

endmodule

// File: src/mavf_acc.sv
// Bit-serial running sum update (sum + new - old) with serial negation for the magnitude.
module mavf_acc #(
  parameter int SUM_W = 38
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  mavf_pkg::acc_ctrl_t                  ctrl,
  input  logic signed [mavf_pkg::SAMPLE_W-1:0] new_word,
  input  logic signed [mavf_pkg::SAMPLE_W-1:0] old_word,
  output logic                                 negative,
  output logic [SUM_W-1:0]                     magnitude
);

  logic [SUM_W-1:0]                     sum_sr;
  logic [SUM_W-1:0]                     neg_sr;
  logic signed [mavf_pkg::SAMPLE_W-1:0] new_sr;
  logic signed [mavf_pkg::SAMPLE_W-1:0] old_sr;
  logic c_add;
  logic c_sub;
  logic c_neg;
  logic t_bit;
  logic r_bit;
  logic n_bit;
  logic o_inv;
  logic c_add_next;
  logic c_sub_next;
  logic c_neg_next;

  always_comb begin
    o_inv      = ~old_sr[0];
    t_bit      = sum_sr[0] ^ new_sr[0] ^ c_add;
    c_add_next = (sum_sr[0] & new_sr[0]) | (c_add & (sum_sr[0] ^ new_sr[0]));
    r_bit      = t_bit ^ o_inv ^ c_sub;
    c_sub_next = (t_bit & o_inv) | (c_sub & (t_bit ^ o_inv));
    n_bit      = ~r_bit ^ c_neg;
    c_neg_next = ~r_bit & c_neg;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_sr <= '0;
    end else if (ctrl.clear) begin
      sum_sr <= '0;
    end else if (ctrl.shift) begin
      sum_sr <= {r_bit, sum_sr[SUM_W-1:1]};
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      new_sr <= new_word;
      old_sr <= old_word;
      c_add  <= 1'b0;
      c_sub  <= 1'b1;
      c_neg  <= 1'b1;
    end else if (ctrl.shift) begin
      new_sr <= new_sr >>> 1;
      old_sr <= old_sr >>> 1;
      neg_sr <= {n_bit, neg_sr[SUM_W-1:1]};
      c_add  <= c_add_next;
      c_sub  <= c_sub_next;
      c_neg  <= c_neg_next;
    end
  end

  assign negative  = sum_sr[SUM_W-1];
  assign magnitude = negative ? neg_sr : sum_sr;

endmodule

// File: src/mavf_div.sv
// Bit-serial restoring divider: magnitude by window length, sign restored at the end.
module mavf_div #(
  parameter int SUM_W = 38,
  parameter int LEN_W = 7
) (
  input  logic                                 clk,
  input  mavf_pkg::div_ctrl_t                  ctrl,
  input  logic [SUM_W-1:0]                     dividend,
  input  logic                                 negative,
  input  logic [LEN_W-1:0]                     divisor,
  output logic signed [mavf_pkg::SAMPLE_W-1:0] quotient
);

  logic [SUM_W-1:0]              dvd_sr;
  logic [LEN_W-1:0]              rem;
  logic [mavf_pkg::SAMPLE_W-1:0] q_sr;
  logic                          neg_r;
  logic [LEN_W:0]                trial;
  logic [LEN_W:0]                diff;
  logic                          q_bit;
  logic [LEN_W-1:0]              rem_next;

  always_comb begin
    trial    = {rem, dvd_sr[SUM_W-1]};
    diff     = trial - {1'b0, divisor};
    q_bit    = ~diff[LEN_W];
    rem_next = q_bit ? diff[LEN_W-1:0] : trial[LEN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      dvd_sr <= dividend;
      rem    <= '0;
      neg_r  <= negative;
    end else if (ctrl.shift) begin
      dvd_sr <= {dvd_sr[SUM_W-2:0], 1'b0};
      rem    <= rem_next;
      q_sr   <= {q_sr[mavf_pkg::SAMPLE_W-2:0], q_bit};
    end
  end

  assign quotient = neg_r ? -q_sr : q_sr;

endmodule
